[rtl/hps_pkg.sv]
package hps_pkg;

	localparam int PATTERN_COUNT_DEF = 6;
	localparam int STEPS_PER_PATTERN_DEF = 22;

	// The pattern table is fixed: six patterns of twenty-two steps.
	localparam int ROM_PATTERNS = 6;
	localparam int ROM_STEPS    = 22;
	localparam int ROM_SLOTS    = 10;
	localparam int ROM_SPAN     = 256;
	localparam int ROM_AW       = $clog2(ROM_SPAN);

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [15:0] FULL_TIME_RST = 16'd100;
	localparam logic [15:0] HALF_TIME_RST = 16'd200;
	localparam logic [15:0] OFF_TIME_RST  = 16'd50;

	typedef enum logic [2:0] {
		OP_TICK  = 3'd0,
		OP_START = 3'd1,
		OP_STOP  = 3'd2,
		OP_PAUSE = 3'd3,
		OP_FASTER = 3'd4,
		OP_SLOWER = 3'd5
	} hps_op_t;

	localparam logic [1:0] LVL_OFF  = 2'd0;
	localparam logic [1:0] LVL_HALF = 2'd1;
	localparam logic [1:0] LVL_FULL = 2'd2;

	localparam logic CMD_SET     = 1'b0;
	localparam logic CMD_ALL_OFF = 1'b1;

	typedef struct packed {
		hps_op_t    op;
		logic [2:0] goal;
	} hps_in_t;

	typedef struct packed {
		logic       cmd_kind;
		logic [2:0] motor_index;
		logic [1:0] drive_level;
		logic       last_of_run;
	} hps_out_t;

	// Up to two result beats written into the output queue in one cycle.
	typedef struct packed {
		logic [1:0] count;
		hps_out_t   first;
		hps_out_t   second;
	} hps_push_t;

	typedef logic [4:0] hps_rom_t [ROM_SPAN];

	localparam logic [2:0] MOTOR_LISTS [ROM_PATTERNS][ROM_SLOTS] = '{
		'{3'd2, 3'd3, 3'd4, 3'd1, 3'd0, 3'd2, 3'd3, 3'd4, 3'd6, 3'd5},
		'{3'd0, 3'd3, 3'd6, 3'd4, 3'd1, 3'd0, 3'd3, 3'd6, 3'd5, 3'd2},
		'{3'd1, 3'd3, 3'd5, 3'd6, 3'd4, 3'd1, 3'd3, 3'd5, 3'd2, 3'd0},
		'{3'd4, 3'd3, 3'd2, 3'd5, 3'd6, 3'd4, 3'd3, 3'd2, 3'd0, 3'd1},
		'{3'd6, 3'd3, 3'd0, 3'd2, 3'd5, 3'd6, 3'd3, 3'd0, 3'd1, 3'd4},
		'{3'd5, 3'd3, 3'd1, 3'd0, 3'd2, 3'd5, 3'd3, 3'd1, 3'd4, 3'd6}
	};

	localparam logic [3:0] TMPL_SLOT [ROM_STEPS] = '{
		4'd0, 4'd1, 4'd2, 4'd3, 4'd3, 4'd3, 4'd3, 4'd4, 4'd4, 4'd4, 4'd4,
		4'd5, 4'd6, 4'd7, 4'd8, 4'd8, 4'd8, 4'd8, 4'd9, 4'd9, 4'd9, 4'd9
	};

	localparam logic [1:0] TMPL_LEVEL [ROM_STEPS] = '{
		2'd2, 2'd2, 2'd2, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd0,
		2'd2, 2'd2, 2'd2, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd0
	};

	// Each entry holds the level in bits 4..3 and the motor in bits 2..0.
	// Addresses past the six patterns read as motor zero, level off.
	function automatic hps_rom_t build_rom();
		hps_rom_t r;
		for (int a = 0; a < ROM_SPAN; a++) begin
			r[a] = 5'd0;
		end
		for (int p = 0; p < ROM_PATTERNS; p++) begin
			for (int s = 0; s < ROM_STEPS; s++) begin
				r[p * ROM_STEPS + s] = {TMPL_LEVEL[s], MOTOR_LISTS[p][TMPL_SLOT[s]]};
			end
		end
		return r;
	endfunction

	localparam hps_rom_t PATTERN_ROM = build_rom();

endpackage

[rtl/hps_outq.sv]
module hps_outq
	import hps_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  hps_push_t push,
	input  logic      pop,
	output hps_out_t  rsp,
	output logic      rsp_valid,
	output logic      room
);

	hps_out_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_PW-1:0]     wr_q;
	logic [QUEUE_PW-1:0]     rd_q;
	logic [QUEUE_CW-1:0]     count_q;
	logic [QUEUE_PW-1:0]     wr_next;

	assign wr_next   = wr_q + QUEUE_PW'(1);
	assign rsp       = mem_q[rd_q];
	assign rsp_valid = (count_q != '0);
	// Room for a whole tick, which writes two beats at once.
	assign room      = (count_q <= QUEUE_CW'(QUEUE_DEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + QUEUE_PW'(push.count);
			rd_q    <= rd_q + QUEUE_PW'(pop);
			count_q <= count_q + QUEUE_CW'(push.count) - QUEUE_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_next] <= push.second;
		end
	end

endmodule

[rtl/hps_core.sv]
module hps_core
	import hps_pkg::*;
#(
	parameter int PATTERN_COUNT     = PATTERN_COUNT_DEF,
	parameter int STEPS_PER_PATTERN = STEPS_PER_PATTERN_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  hps_in_t   item,
	output hps_push_t push
);

	// Reciprocal of ten at 2^-23; exact for dividends below 2^22.
	localparam logic [19:0] RECIP10 = 20'd838861;

	logic [2:0]  pattern_q;
	logic [4:0]  step_q;
	logic        running_q;
	logic        paused_q;
	logic [2:0]  prior_q;
	logic [15:0] remain_q;
	logic [15:0] full_q;
	logic [15:0] half_q;
	logic [15:0] off_q;

	logic [2:0]  pattern_d;
	logic [4:0]  step_d;
	logic        running_d;
	logic        paused_d;
	logic [2:0]  prior_d;
	logic [15:0] remain_d;
	logic [15:0] full_d;
	logic [15:0] half_d;
	logic [15:0] off_d;

	logic [ROM_AW-1:0] rom_addr;
	logic [4:0]        entry;
	logic [2:0]        motor;
	logic [1:0]        level;
	logic [15:0]       step_time;
	logic [4:0]        step_inc;
	logic              step_wrap;
	logic              goal_ok;

	function automatic logic [15:0] scale_down(input logic [15:0] t);
		logic [19:0] x;
		logic [39:0] p;
		x = (20'(t) << 3) + 20'(t);
		p = 40'(x) * 40'(RECIP10);
		return p[38:23];
	endfunction

	function automatic logic [15:0] scale_up(input logic [15:0] t);
		logic [19:0] x;
		logic [39:0] p;
		logic [16:0] q;
		x = (20'(t) << 3) + (20'(t) << 1) + 20'(t);
		p = 40'(x) * 40'(RECIP10);
		q = p[39:23];
		return q[16] ? 16'hFFFF : q[15:0];
	endfunction

	assign rom_addr  = ROM_AW'(pattern_q) * ROM_AW'(STEPS_PER_PATTERN) + ROM_AW'(step_q);
	assign entry     = PATTERN_ROM[rom_addr];
	assign motor     = entry[2:0];
	assign level     = entry[4:3];
	assign step_time = (level == LVL_FULL) ? full_q :
	                   (level == LVL_HALF) ? half_q : off_q;
	assign step_inc  = step_q + 5'd1;
	assign step_wrap = ({1'b0, step_q} + 6'd1 >= 6'(STEPS_PER_PATTERN));
	assign goal_ok   = ({1'b0, item.goal} < 4'(PATTERN_COUNT));

	always_comb begin
		pattern_d = pattern_q;
		step_d    = step_q;
		running_d = running_q;
		paused_d  = paused_q;
		prior_d   = prior_q;
		remain_d  = remain_q;
		full_d    = full_q;
		half_d    = half_q;
		off_d     = off_q;
		push      = '0;
		if (fire) begin
			unique case (item.op)
				OP_TICK: begin
					if (running_q) begin
						if (remain_q != 16'd0) begin
							remain_d = remain_q - 16'd1;
						end else if (!paused_q) begin
							push.count  = 2'd2;
							push.first  = '{CMD_SET, prior_q, LVL_OFF, 1'b0};
							push.second = '{CMD_SET, motor, level, 1'b1};
							remain_d    = step_time;
							prior_d     = motor;
							step_d      = step_wrap ? 5'd0 : step_inc;
						end
					end
				end
				OP_START: begin
					if (goal_ok) begin
						pattern_d = item.goal;
						step_d    = 5'd0;
						remain_d  = 16'd0;
						running_d = 1'b1;
					end
				end
				OP_STOP: begin
					running_d  = 1'b0;
					push.count = 2'd1;
					push.first = '{CMD_ALL_OFF, 3'd0, LVL_OFF, 1'b1};
				end
				OP_PAUSE: begin
					paused_d = !paused_q;
				end
				OP_FASTER: begin
					full_d = scale_down(full_q);
					half_d = scale_down(half_q);
					off_d  = scale_down(off_q);
				end
				OP_SLOWER: begin
					full_d = scale_up(full_q);
					half_d = scale_up(half_q);
					off_d  = scale_up(off_q);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			step_q    <= '0;
			running_q <= 1'b0;
			paused_q  <= 1'b0;
			prior_q   <= '0;
			remain_q  <= '0;
			full_q    <= FULL_TIME_RST;
			half_q    <= HALF_TIME_RST;
			off_q     <= OFF_TIME_RST;
		end else begin
			pattern_q <= pattern_d;
			step_q    <= step_d;
			running_q <= running_d;
			paused_q  <= paused_d;
			prior_q   <= prior_d;
			remain_q  <= remain_d;
			full_q    <= full_d;
			half_q    <= half_d;
			off_q     <= off_d;
		end
	end

endmodule

[rtl/haptic_pattern_sequencer_unit.sv]
// Haptic pattern sequencer.
// The req channel takes one command beat per cycle while req_ready is high
// (tick, start, stop, pause toggle, speed up, slow down) with a goal pattern
// number for start. The rsp channel returns motor commands: a tick that fires
// a step gives two beats (previous motor off, then the new motor and level),
// a stop gives one all-off beat, and every other command gives none. The final
// beat of each command carries last_of_run.
// A command is held in an input register and executed there; its beats are
// written into a four-entry output queue and shown from it in order. req_ready
// drops only while the queue holds more than two beats, so a command is
// accepted every cycle as long as the receiver keeps up; a stalled receiver
// fills the queue and then holds req_ready low until it drains.
// Reset stops playback, clears pause and the countdown, and restores the step
// times to 100, 200 and 50 ms for full, half and off; the queue comes up empty.
module haptic_pattern_sequencer_unit
	import hps_pkg::*;
#(
	parameter int PATTERN_COUNT     = PATTERN_COUNT_DEF,
	parameter int STEPS_PER_PATTERN = STEPS_PER_PATTERN_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  hps_in_t  req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output hps_out_t rsp
);

	hps_in_t   req_s1;
	logic      req_valid_s1;
	logic      fire;
	logic      room;
	hps_push_t push;

	assign fire      = req_valid_s1 && room;
	assign req_ready = !req_valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (req_valid && req_ready) begin
			req_valid_s1 <= 1'b1;
		end else if (fire) begin
			req_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	hps_core #(
		.PATTERN_COUNT     (PATTERN_COUNT),
		.STEPS_PER_PATTERN (STEPS_PER_PATTERN)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (req_s1),
		.push   (push)
	);

	hps_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (rsp_valid && rsp_ready),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.room      (room)
	);

endmodule
